/* rtl/wavp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared tags, codes, result beat type and status helpers of the WAV parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned FMT_BODY_LEN = 16;
  localparam logic [15:0] PCM_TAG      = 16'd1;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF    = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
  localparam logic [2:0] ST_NO_FMT      = 3'd3;
  localparam logic [2:0] ST_NO_DATA     = 3'd4;
  localparam logic [2:0] ST_NOT_PCM     = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [2:0]  status_code;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic        last_of_run;
  } beat_t;

  // up to two beats from one input byte, data beat first
  typedef struct packed {
    logic [1:0] cnt;
    beat_t      beat0;
    beat_t      beat1;
  } push_t;

  function automatic logic [2:0] final_code(input logic        found_fmt,
                                            input logic        found_data,
                                            input logic [15:0] ftag,
                                            input logic [15:0] chan,
                                            input logic [15:0] bits);
    logic [2:0] code;
    if (!found_fmt) begin
      code = ST_NO_FMT;
    end else if (!found_data) begin
      code = ST_NO_DATA;
    end else if (ftag != PCM_TAG) begin
      code = ST_NOT_PCM;
    end else if ((chan == 16'd1 || chan == 16'd2) && (bits == 16'd8 || bits == 16'd16)) begin
      code = ST_OK;
    end else begin
      code = ST_UNSUPPORTED;
    end
    return code;
  endfunction

  function automatic beat_t status_beat(input logic [2:0]  code,
                                        input logic [31:0] rate,
                                        input logic [15:0] chan,
                                        input logic [15:0] bits);
    beat_t b;
    b.result_kind   = KIND_STATUS;
    b.data_byte     = 8'd0;
    b.status_code   = code;
    b.format_code   = (code == ST_OK) ? {chan == 16'd2, bits == 16'd16} : 2'd0;
    b.sample_rate   = rate;
    b.channel_count = chan;
    b.sample_bits   = bits;
    b.last_of_run   = 1'b1;
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/wavp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_core
// Byte-wise RIFF/WAVE parser state machine; one byte per step, up to two beats.
// ----------------------------------------------------------------------------
module wavp_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     byte_value,
  input  wire logic           end_of_file,
  output wavp_pkg::push_t     push
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_FSIZE, PH_WAVE, PH_ID, PH_SZ_FMT, PH_SZ_DATA, PH_SZ_SKIP,
    PH_FMT, PH_DATA, PH_SKIP, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fpos_r, fpos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [15:0] ftag_r, ftag_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        found_fmt_r, found_fmt_nxt;
  logic        found_data_r, found_data_nxt;

  logic        data_v;
  logic        stat_v;
  logic [2:0]  stat_code;
  wavp_pkg::beat_t data_beat;
  wavp_pkg::beat_t stat_beat;

  always_comb begin
    phase_nxt      = phase_r;
    fpos_nxt       = fpos_r;
    tag_nxt        = tag_r;
    remain_nxt     = remain_r;
    ftag_nxt       = ftag_r;
    chan_nxt       = chan_r;
    rate_nxt       = rate_r;
    bits_nxt       = bits_r;
    found_fmt_nxt  = found_fmt_r;
    found_data_nxt = found_data_r;
    data_v         = 1'b0;
    stat_v         = 1'b0;
    stat_code      = wavp_pkg::ST_OK;

    if (step) begin
      case (phase_r)
        PH_RIFF, PH_FSIZE, PH_WAVE, PH_ID: begin
          tag_nxt  = {tag_r[23:0], byte_value};
          fpos_nxt = fpos_r + 4'd1;
          if (fpos_r == 4'd3) begin
            fpos_nxt = 4'd0;
            case (phase_r)
              PH_RIFF: begin
                if (tag_nxt != wavp_pkg::TAG_RIFF) begin
                  stat_v    = 1'b1;
                  stat_code = wavp_pkg::ST_NOT_RIFF;
                end else begin
                  phase_nxt = PH_FSIZE;
                end
              end
              PH_FSIZE: phase_nxt = PH_WAVE;
              PH_WAVE: begin
                if (tag_nxt != wavp_pkg::TAG_WAVE) begin
                  stat_v    = 1'b1;
                  stat_code = wavp_pkg::ST_NOT_WAVE;
                end else begin
                  phase_nxt = PH_ID;
                end
              end
              default: begin
                remain_nxt = 32'd0;
                if (tag_nxt == wavp_pkg::TAG_FMT) begin
                  phase_nxt = PH_SZ_FMT;
                end else if (tag_nxt == wavp_pkg::TAG_DATA) begin
                  phase_nxt = PH_SZ_DATA;
                end else begin
                  phase_nxt = PH_SZ_SKIP;
                end
              end
            endcase
          end
        end
        PH_SZ_FMT, PH_SZ_DATA, PH_SZ_SKIP: begin
          remain_nxt[{fpos_r[1:0], 3'b000} +: 8] = byte_value;
          fpos_nxt = fpos_r + 4'd1;
          if (fpos_r == 4'd3) begin
            fpos_nxt = 4'd0;
            if (phase_r == PH_SZ_FMT) begin
              phase_nxt = PH_FMT;
            end else if (phase_r == PH_SZ_DATA) begin
              if (remain_nxt == 32'd0) begin
                found_data_nxt = 1'b1;
                if (found_fmt_r) begin
                  stat_v    = 1'b1;
                  stat_code = wavp_pkg::final_code(found_fmt_r, 1'b1, ftag_r, chan_r, bits_r);
                end else begin
                  phase_nxt = PH_ID;
                end
              end else begin
                phase_nxt = PH_DATA;
              end
            end else begin
              phase_nxt = (remain_nxt == 32'd0) ? PH_ID : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (fpos_r < 4'd2) begin
            ftag_nxt[{fpos_r[0], 3'b000} +: 8] = byte_value;
          end else if (fpos_r < 4'd4) begin
            chan_nxt[{fpos_r[0], 3'b000} +: 8] = byte_value;
          end else if (fpos_r < 4'd8) begin
            rate_nxt[{fpos_r[1:0], 3'b000} +: 8] = byte_value;
          end else if (fpos_r >= 4'd14) begin
            bits_nxt[{fpos_r[0], 3'b000} +: 8] = byte_value;
          end
          fpos_nxt = fpos_r + 4'd1;
          if (fpos_r == 4'(wavp_pkg::FMT_BODY_LEN - 1)) begin
            fpos_nxt      = 4'd0;
            found_fmt_nxt = 1'b1;
            if (found_data_r) begin
              stat_v    = 1'b1;
              stat_code = wavp_pkg::final_code(1'b1, found_data_r, ftag_nxt, chan_nxt,
                                               bits_nxt);
            end else if (remain_r > 32'(wavp_pkg::FMT_BODY_LEN)) begin
              remain_nxt = remain_r - 32'(wavp_pkg::FMT_BODY_LEN);
              phase_nxt  = PH_SKIP;
            end else begin
              phase_nxt = PH_ID;
            end
          end
        end
        PH_DATA: begin
          data_v     = 1'b1;
          remain_nxt = remain_r - 32'd1;
          if (remain_nxt == 32'd0) begin
            found_data_nxt = 1'b1;
            if (found_fmt_r) begin
              stat_v    = 1'b1;
              stat_code = wavp_pkg::final_code(found_fmt_r, 1'b1, ftag_r, chan_r, bits_r);
            end else begin
              phase_nxt = PH_ID;
            end
          end
        end
        PH_SKIP: begin
          remain_nxt = remain_r - 32'd1;
          if (remain_nxt == 32'd0) begin
            phase_nxt = PH_ID;
          end
        end
        default: begin
        end
      endcase

      if (stat_v) begin
        phase_nxt = PH_DONE;
      end

      if (end_of_file && !stat_v && phase_nxt != PH_DONE) begin
        if (phase_nxt inside {PH_SZ_FMT, PH_FMT}) begin
          found_fmt_nxt = 1'b1;
        end
        if (phase_nxt inside {PH_SZ_DATA, PH_DATA}) begin
          found_data_nxt = 1'b1;
        end
        stat_v = 1'b1;
        if (phase_nxt == PH_RIFF) begin
          stat_code = wavp_pkg::ST_NOT_RIFF;
        end else if (phase_nxt inside {PH_FSIZE, PH_WAVE}) begin
          stat_code = wavp_pkg::ST_NOT_WAVE;
        end else begin
          stat_code = wavp_pkg::final_code(found_fmt_nxt, found_data_nxt, ftag_nxt,
                                           chan_nxt, bits_nxt);
        end
      end
    end

    data_beat               = '0;
    data_beat.result_kind   = wavp_pkg::KIND_DATA;
    data_beat.data_byte     = byte_value;
    data_beat.last_of_run   = !stat_v;
    stat_beat               = wavp_pkg::status_beat(stat_code, rate_nxt, chan_nxt, bits_nxt);

    push.cnt   = {1'b0, data_v} + {1'b0, stat_v};
    push.beat0 = data_v ? data_beat : stat_beat;
    push.beat1 = stat_beat;

    if (step && end_of_file) begin
      phase_nxt      = PH_RIFF;
      fpos_nxt       = 4'd0;
      tag_nxt        = 32'd0;
      remain_nxt     = 32'd0;
      ftag_nxt       = 16'd0;
      chan_nxt       = 16'd0;
      rate_nxt       = 32'd0;
      bits_nxt       = 16'd0;
      found_fmt_nxt  = 1'b0;
      found_data_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RIFF;
      fpos_r       <= 4'd0;
      tag_r        <= 32'd0;
      remain_r     <= 32'd0;
      ftag_r       <= 16'd0;
      chan_r       <= 16'd0;
      rate_r       <= 32'd0;
      bits_r       <= 16'd0;
      found_fmt_r  <= 1'b0;
      found_data_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      fpos_r       <= fpos_nxt;
      tag_r        <= tag_nxt;
      remain_r     <= remain_nxt;
      ftag_r       <= ftag_nxt;
      chan_r       <= chan_nxt;
      rate_r       <= rate_nxt;
      bits_r       <= bits_nxt;
      found_fmt_r  <= found_fmt_nxt;
      found_data_r <= found_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_two_beat_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.beat0.result_kind == wavp_pkg::KIND_DATA &&
                         !push.beat0.last_of_run &&
                         push.beat1.result_kind == wavp_pkg::KIND_STATUS &&
                         push.beat1.last_of_run)
    else $error("two-beat step out of order");

  a_status_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat_v && !end_of_file |=> phase_r == PH_DONE)
    else $error("status sent but parser not done");
`endif

endmodule
`default_nettype wire

/* rtl/wavp_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_fifo
// Small result queue taking up to two beats per cycle and giving one unless out_stall holds it.
// ----------------------------------------------------------------------------
module wavp_fifo #(
  parameter int unsigned DEPTH = wavp_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wavp_pkg::push_t push,
  output logic                 full2,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output wavp_pkg::beat_t      out_beat
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);

  wavp_pkg::beat_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign full2     = (count_r > CW'(DEPTH - 2));
  assign out_beat  = mem_r[rd_r];

  always_comb begin
    case (push.cnt)
      2'd1:    wr_nxt = ptr_inc(wr_r);
      2'd2:    wr_nxt = ptr_inc(ptr_inc(wr_r));
      default: wr_nxt = wr_r;
    endcase
    rd_nxt    = pop ? ptr_inc(rd_r) : rd_r;
    count_nxt = CW'(count_r + CW'(push.cnt) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.beat0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[ptr_inc(wr_r)] <= push.beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count past depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= CW'(DEPTH - 2))
    else $error("push without room for two beats");
`endif

endmodule
`default_nettype wire

/* rtl/wav_header_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE PCM header parser: checks tags, reads the fmt fields, passes
// data-chunk bytes through and reports one status beat per file.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    byte_value, end_of_file
// out_      output     out_valid / out_stall  kind, byte, status, fmt fields, last
//
// one byte accepted per cycle unless in_stall holds it; its beats are registered in the queue
// a byte that ends the data chunk or the file may give a data and a status beat
// in_stall rises while the result queue has fewer than two free entries
// synchronous reset clears the parser and queue; end of file also resets parser
// ----------------------------------------------------------------------------
module wav_header_parser #(
  parameter int unsigned FIFO_DEPTH = wavp_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_data_byte,
  output logic [2:0]       out_status_code,
  output logic [1:0]       out_format_code,
  output logic [31:0]      out_sample_rate,
  output logic [15:0]      out_channel_count,
  output logic [15:0]      out_sample_bits,
  output logic             out_last_of_run
);

  wavp_pkg::push_t push;
  wavp_pkg::beat_t beat;
  logic            step;

  assign step = in_valid && !in_stall;

  wavp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .byte_value  (in_byte_value),
    .end_of_file (in_end_of_file),
    .push        (push)
  );

  wavp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (beat)
  );

  assign out_result_kind   = beat.result_kind;
  assign out_data_byte     = beat.data_byte;
  assign out_status_code   = beat.status_code;
  assign out_format_code   = beat.format_code;
  assign out_sample_rate   = beat.sample_rate;
  assign out_channel_count = beat.channel_count;
  assign out_sample_bits   = beat.sample_bits;
  assign out_last_of_run   = beat.last_of_run;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the WAV header parser. WAV streams are fed a byte per beat:
// directed files first, then random files, mostly well formed. A byte-wise
// parser model predicts every result beat, and each beat that leaves the
// block is compared field by field, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    PH_RIFF_TAG, PH_FILE_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_FMT_SIZE, PH_DATA_SIZE,
    PH_SKIP_SIZE, PH_FMT_BODY, PH_DATA_BODY, PH_SKIP_BODY, PH_DONE
  } parse_phase_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'd0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_status_code;
  logic [1:0]  out_format_code;
  logic [31:0] out_sample_rate;
  logic [15:0] out_channel_count;
  logic [15:0] out_sample_bits;
  logic        out_last_of_run;

  // parser model state
  parse_phase_t m_phase;
  int unsigned  m_pos;
  logic [31:0]  m_shift;
  logic [31:0]  m_remain;
  logic [15:0]  m_ftag;
  logic [15:0]  m_chan;
  logic [31:0]  m_rate;
  logic [15:0]  m_bits;
  logic         m_have_fmt;
  logic         m_have_data;
  logic         m_reported;

  wavp_pkg::beat_t step_beats[$];
  wavp_pkg::beat_t pending_beats[$];
  logic [7:0]      wav_q[$];

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 69;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned live_bytes = 0;
  int unsigned sent_bytes = 0;
  int unsigned files_sent = 0;
  int unsigned data_beats = 0;
  int unsigned status_beats = 0;
  int unsigned code_hits[7];

  wav_header_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_data_byte    (out_data_byte),
    .out_status_code  (out_status_code),
    .out_format_code  (out_format_code),
    .out_sample_rate  (out_sample_rate),
    .out_channel_count(out_channel_count),
    .out_sample_bits  (out_sample_bits),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------- model

  task automatic model_reset();
    m_phase     = PH_RIFF_TAG;
    m_pos       = 0;
    m_shift     = '0;
    m_remain    = '0;
    m_ftag      = '0;
    m_chan      = '0;
    m_rate      = '0;
    m_bits      = '0;
    m_have_fmt  = 1'b0;
    m_have_data = 1'b0;
    m_reported  = 1'b0;
  endtask

  function automatic logic [2:0] file_verdict();
    if (!m_have_fmt) return wavp_pkg::ST_NO_FMT;
    if (!m_have_data) return wavp_pkg::ST_NO_DATA;
    if (m_ftag != wavp_pkg::PCM_TAG) return wavp_pkg::ST_NOT_PCM;
    if ((m_chan == 16'd1 || m_chan == 16'd2) && (m_bits == 16'd8 || m_bits == 16'd16))
      return wavp_pkg::ST_OK;
    return wavp_pkg::ST_UNSUPPORTED;
  endfunction

  task automatic add_status(input logic [2:0] code);
    wavp_pkg::beat_t s;
    s = '0;
    s.result_kind   = wavp_pkg::KIND_STATUS;
    s.status_code   = code;
    s.format_code   = (code == wavp_pkg::ST_OK) ? {m_chan == 16'd2, m_bits == 16'd16} : 2'd0;
    s.sample_rate   = m_rate;
    s.channel_count = m_chan;
    s.sample_bits   = m_bits;
    step_beats.push_back(s);
    m_reported = 1'b1;
    m_phase    = PH_DONE;
  endtask

  task automatic data_found();
    m_have_data = 1'b1;
    if (m_have_fmt) add_status(file_verdict());
    else m_phase = PH_CHUNK_ID;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    wavp_pkg::beat_t d;
    logic [2:0] code;
    step_beats.delete();
    if (!m_reported) begin
      live_bytes++;
      case (m_phase)
        PH_RIFF_TAG, PH_FILE_SIZE, PH_WAVE_TAG, PH_CHUNK_ID: begin
          m_shift = {m_shift[23:0], b};
          m_pos++;
          if (m_pos >= 4) begin
            m_pos = 0;
            case (m_phase)
              PH_RIFF_TAG: begin
                if (m_shift != wavp_pkg::TAG_RIFF) add_status(wavp_pkg::ST_NOT_RIFF);
                else m_phase = PH_FILE_SIZE;
              end
              PH_FILE_SIZE: m_phase = PH_WAVE_TAG;
              PH_WAVE_TAG: begin
                if (m_shift != wavp_pkg::TAG_WAVE) add_status(wavp_pkg::ST_NOT_WAVE);
                else m_phase = PH_CHUNK_ID;
              end
              default: begin
                m_remain = '0;
                if (m_shift == wavp_pkg::TAG_FMT) m_phase = PH_FMT_SIZE;
                else if (m_shift == wavp_pkg::TAG_DATA) m_phase = PH_DATA_SIZE;
                else m_phase = PH_SKIP_SIZE;
              end
            endcase
          end
        end
        PH_FMT_SIZE, PH_DATA_SIZE, PH_SKIP_SIZE: begin
          m_remain[8*m_pos +: 8] = b;
          m_pos++;
          if (m_pos >= 4) begin
            m_pos = 0;
            if (m_phase == PH_FMT_SIZE) begin
              m_phase = PH_FMT_BODY;
            end else if (m_phase == PH_DATA_SIZE) begin
              if (m_remain == 0) data_found();
              else m_phase = PH_DATA_BODY;
            end else begin
              m_phase = (m_remain == 0) ? PH_CHUNK_ID : PH_SKIP_BODY;
            end
          end
        end
        PH_FMT_BODY: begin
          if (m_pos < 2) m_ftag[8*m_pos +: 8] = b;
          else if (m_pos < 4) m_chan[8*(m_pos-2) +: 8] = b;
          else if (m_pos < 8) m_rate[8*(m_pos-4) +: 8] = b;
          else if (m_pos >= 14) m_bits[8*(m_pos-14) +: 8] = b;
          m_pos++;
          if (m_pos >= wavp_pkg::FMT_BODY_LEN) begin
            m_pos = 0;
            m_have_fmt = 1'b1;
            if (m_have_data) begin
              add_status(file_verdict());
            end else if (m_remain > wavp_pkg::FMT_BODY_LEN) begin
              m_remain = m_remain - wavp_pkg::FMT_BODY_LEN;
              m_phase  = PH_SKIP_BODY;
            end else begin
              m_phase = PH_CHUNK_ID;
            end
          end
        end
        PH_DATA_BODY: begin
          d = '0;
          d.result_kind = wavp_pkg::KIND_DATA;
          d.data_byte   = b;
          step_beats.push_back(d);
          m_remain--;
          if (m_remain == 0) data_found();
        end
        PH_SKIP_BODY: begin
          m_remain--;
          if (m_remain == 0) m_phase = PH_CHUNK_ID;
        end
        default: ;
      endcase
    end
    if (eof) begin
      if (!m_reported) begin
        if (m_phase == PH_FMT_SIZE || m_phase == PH_FMT_BODY) m_have_fmt = 1'b1;
        if (m_phase == PH_DATA_SIZE || m_phase == PH_DATA_BODY) m_have_data = 1'b1;
        if (m_phase == PH_RIFF_TAG) code = wavp_pkg::ST_NOT_RIFF;
        else if (m_phase == PH_FILE_SIZE || m_phase == PH_WAVE_TAG)
          code = wavp_pkg::ST_NOT_WAVE;
        else code = file_verdict();
        add_status(code);
      end
      model_reset();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last_of_run = 1'b1;
    foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    wavp_pkg::beat_t w;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        w = pending_beats.pop_front();
        check_field("result_kind", 32'(w.result_kind), 32'(out_result_kind));
        check_field("data_byte", 32'(w.data_byte), 32'(out_data_byte));
        check_field("status_code", 32'(w.status_code), 32'(out_status_code));
        check_field("format_code", 32'(w.format_code), 32'(out_format_code));
        check_field("sample_rate", w.sample_rate, out_sample_rate);
        check_field("channel_count", 32'(w.channel_count), 32'(out_channel_count));
        check_field("sample_bits", 32'(w.sample_bits), 32'(out_sample_bits));
        check_field("last_of_run", 32'(w.last_of_run), 32'(out_last_of_run));
        if (w.result_kind == wavp_pkg::KIND_STATUS) begin
          status_beats++;
          code_hits[w.status_code]++;
        end else begin
          data_beats++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_value  <= b;
    in_end_of_file <= eof;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_bytes++;
    predict_byte(b, eof);
  endtask

  task automatic send_file();
    for (int i = 0; i < wav_q.size(); i++) send_byte(wav_q[i], i == wav_q.size() - 1);
    wav_q.delete();
    files_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic put_tag(input logic [31:0] v);
    wav_q.push_back(v[31:24]);
    wav_q.push_back(v[23:16]);
    wav_q.push_back(v[15:8]);
    wav_q.push_back(v[7:0]);
  endtask

  task automatic put_u16(input logic [15:0] v);
    wav_q.push_back(v[7:0]);
    wav_q.push_back(v[15:8]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endtask

  task automatic put_noise(input int unsigned n);
    repeat (n) wav_q.push_back(8'($urandom()));
  endtask

  task automatic put_header();
    put_tag(wavp_pkg::TAG_RIFF);
    put_u32($urandom());
    put_tag(wavp_pkg::TAG_WAVE);
  endtask

  task automatic put_fmt(input logic [15:0] ftag, input logic [15:0] chan,
                         input logic [31:0] rate, input logic [15:0] bits,
                         input logic [31:0] size);
    put_tag(wavp_pkg::TAG_FMT);
    put_u32(size);
    put_u16(ftag);
    put_u16(chan);
    put_u32(rate);
    put_u32($urandom());
    put_u16(16'($urandom()));
    put_u16(bits);
    if (size > 16) put_noise((size - 16 > 10) ? 10 : size - 16);
  endtask

  task automatic put_data(input logic [31:0] size);
    put_tag(wavp_pkg::TAG_DATA);
    put_u32(size);
    put_noise((size > 40) ? $urandom_range(0, 8) : size);
  endtask

  task automatic put_other(input logic [31:0] size);
    put_tag($urandom());
    put_u32(size);
    put_noise((size > 10) ? $urandom_range(0, 6) : size);
  endtask

  task automatic rand_fmt();
    logic [15:0] ftag;
    logic [15:0] chan;
    logic [15:0] bits;
    logic [31:0] size;
    int unsigned roll;
    ftag = ($urandom_range(9) != 0) ? wavp_pkg::PCM_TAG : 16'($urandom());
    chan = ($urandom_range(6) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom());
    bits = ($urandom_range(6) != 0) ? ($urandom_range(1) ? 16'd16 : 16'd8)
                                    : 16'($urandom());
    roll = $urandom_range(99);
    if (roll < 70) size = 16;
    else if (roll < 85) size = $urandom_range(17, 24);
    else if (roll < 95) size = $urandom_range(0, 15);
    else size = $urandom();
    put_fmt(ftag, chan, $urandom(), bits, size);
  endtask

  task automatic rand_data();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) put_data($urandom_range(0, 12));
    else if (roll < 95) put_data($urandom_range(13, 40));
    else put_data($urandom());
  endtask

  task automatic rand_other();
    put_other(($urandom_range(9) != 0) ? $urandom_range(0, 10) : $urandom());
  endtask

  task automatic rand_file();
    int unsigned roll;
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    roll = $urandom_range(99);
    if (roll < 8) begin
      put_noise($urandom_range(1, 12));
    end else begin
      put_tag((roll < 12) ? wavp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31))
                          : wavp_pkg::TAG_RIFF);
      put_u32($urandom());
      put_tag((roll >= 12 && roll < 16) ? wavp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(31))
                                        : wavp_pkg::TAG_WAVE);
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(3) == 0) rand_other();
        rand_fmt();
        if ($urandom_range(3) == 0) rand_other();
        rand_data();
      end else begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 35) rand_fmt();
          else if (pick < 70) rand_data();
          else rand_other();
        end
      end
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, wav_q.size());
      wav_q = wav_q[0:cut-1];
    end else begin
      put_noise($urandom_range(0, 4));
    end
    send_file();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_bad_tags();
    put_tag(wavp_pkg::TAG_RIFF ^ 32'h1);
    put_noise(2);
    send_file();
    put_tag(wavp_pkg::TAG_RIFF);
    wav_q = wav_q[0:1];
    send_file();
    wav_q.push_back(8'hFF);
    send_file();
    put_tag(wavp_pkg::TAG_RIFF);
    put_u32(32'h0);
    put_tag(wavp_pkg::TAG_WAVE ^ 32'h100);
    send_file();
    put_tag(wavp_pkg::TAG_RIFF);
    put_u16(16'h1234);
    send_file();
    put_tag(wavp_pkg::TAG_RIFF);
    put_u32(32'hFFFF_FFFF);
    put_tag(wavp_pkg::TAG_WAVE);
    wav_q = wav_q[0:9];
    send_file();
    wait_drain();
  endtask

  task automatic test_status_codes();
    put_header();
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd2, 32'd44100, 16'd16, 32'd16);
    send_file();
    put_header();
    put_fmt(16'd3, 16'd1, 32'd8000, 16'd8, 32'd16);
    put_data(32'd2);
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd3, 32'd8000, 16'd8, 32'd16);
    put_data(32'd1);
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd8000, 16'd24, 32'd16);
    put_data(32'd1);
    send_file();
    for (int k = 0; k < 4; k++) begin
      put_header();
      put_fmt(wavp_pkg::PCM_TAG, k[1] ? 16'd2 : 16'd1, 32'd22050, k[0] ? 16'd16 : 16'd8,
              32'd16);
      put_data(32'd1);
      put_noise(2);
      send_file();
    end
    wait_drain();
  endtask

  task automatic test_truncation();
    put_header();
    put_tag(wavp_pkg::TAG_FMT);
    put_u16(16'd16);
    send_file();
    put_header();
    put_tag(wavp_pkg::TAG_FMT);
    put_u32(32'd16);
    put_u16(wavp_pkg::PCM_TAG);
    put_u16(16'd2);
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd11025, 16'd8, 32'd16);
    put_tag(wavp_pkg::TAG_DATA);
    put_u16(16'd5);
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd2, 32'd11025, 16'd8, 32'd16);
    put_tag(wavp_pkg::TAG_DATA);
    put_u32(32'd10);
    put_noise(3);
    send_file();
    wait_drain();
  endtask

  task automatic test_chunk_order();
    put_header();
    put_data(32'd3);
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd8000, 16'd8, 32'd20);
    send_file();
    put_header();
    put_other(32'd0);
    put_fmt(wavp_pkg::PCM_TAG, 16'd2, 32'd48000, 16'd16, 32'd8);
    put_other(32'd5);
    put_data(32'd0);
    put_noise(2);
    send_file();
    wait_drain();
  endtask

  task automatic test_repeats();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd8000, 16'd8, 32'd16);
    put_fmt(wavp_pkg::PCM_TAG, 16'd2, 32'd96000, 16'd16, 32'd16);
    put_data(32'd2);
    send_file();
    put_header();
    put_data(32'd2);
    put_data(32'd1);
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd16000, 16'd16, 32'd16);
    send_file();
    wait_drain();
  endtask

  task automatic test_extremes();
    put_header();
    put_fmt(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd16);
    put_data(32'd2);
    send_file();
    put_header();
    put_fmt(wavp_pkg::PCM_TAG, 16'd1, 32'd0, 16'd8, 32'd16);
    put_tag(wavp_pkg::TAG_DATA);
    put_u32(32'd4);
    wav_q.push_back(8'h00);
    wav_q.push_back(8'hFF);
    wav_q.push_back(8'h55);
    wav_q.push_back(8'hAA);
    send_file();
    wait_drain();
  endtask

  task automatic test_random_files(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned quota);
    int unsigned start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = sent_bytes;
    while (sent_bytes - start < quota) rand_file();
    wait_drain();
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_bad_tags();
    test_status_codes();
    test_truncation();
    test_chunk_order();
    test_repeats();
    test_extremes();
    test_random_files(22, 69, 350);
    test_random_files(69, 22, 350);
    test_random_files(0, 0, 350);
    repeat (16) @(posedge clk);
    $display("%0d files, %0d bytes sent, %0d parsed, %0d data beats, %0d status beats checked",
             files_sent, sent_bytes, live_bytes, data_beats, status_beats);
    $display("status mix ok/riff/wave/fmt/data/pcm/unsup: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5], code_hits[6]);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
